/* hdl/lsma_pkg.sv */
// Shared types, widths and operation codes for the limb-serial multiprecision ALU.
package lsma_pkg;

  localparam int unsigned DataW  = 32;
  localparam int unsigned LimbW  = 32;
  localparam int unsigned KindW  = 3;
  localparam int unsigned QDepth = 2;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  localparam logic [KindW-1:0] KIND_ADD = 3'd0;
  localparam logic [KindW-1:0] KIND_SUB = 3'd1;
  localparam logic [KindW-1:0] KIND_MUL = 3'd2;
  localparam logic [KindW-1:0] KIND_AND = 3'd3;
  localparam logic [KindW-1:0] KIND_CMP = 3'd4;

  localparam logic [1:0] VERDICT_EQ = 2'b00;
  localparam logic [1:0] VERDICT_GT = 2'b01;
  localparam logic [1:0] VERDICT_LT = 2'b11;

  typedef enum logic [2:0] {
    OP_ADD,
    OP_SUB,
    OP_MUL,
    OP_AND,
    OP_CMP,
    OP_NOP
  } op_e;

  typedef struct packed {
    op_e              op;
    logic [LimbW-1:0] a;
    logic [LimbW-1:0] b;
    logic             first;
    logic             last;
  } cmd_t;

  typedef struct packed {
    logic [DataW-1:0] limb;
    logic [DataW-1:0] carry;
    logic [1:0]       verdict;
    logic             done;
  } res_t;

endpackage

/* hdl/lsma_front.sv */
// Front end: accepts limb requests, decodes the operation and queues commands.
module lsma_front (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push,
  output logic                       full,
  input  logic [lsma_pkg::KindW-1:0] kind_i,
  input  logic [lsma_pkg::DataW-1:0] a_limb_i,
  input  logic [lsma_pkg::DataW-1:0] b_limb_i,
  input  logic                       first_i,
  input  logic                       last_i,
  output logic                       cmd_valid_o,
  output lsma_pkg::cmd_t             cmd_o,
  input  logic                       cmd_take_i
);

  lsma_pkg::cmd_t                   cmd_in;
  lsma_pkg::cmd_t                   cmd_q [lsma_pkg::QDepth];
  logic [lsma_pkg::QPtrW-1:0]       wr_ptr_q, wr_ptr_d;
  logic [lsma_pkg::QPtrW-1:0]       rd_ptr_q, rd_ptr_d;
  logic [lsma_pkg::QCntW-1:0]       cnt_q, cnt_d;
  logic                             wr_en;
  logic                             rd_en;

  // Classify the request; unused kinds: a no-op holding state unless first.
  always_comb begin
    cmd_in.a     = a_limb_i[lsma_pkg::LimbW-1:0];
    cmd_in.b     = b_limb_i[lsma_pkg::LimbW-1:0];
    cmd_in.first = first_i;
    cmd_in.last  = last_i;
    case (kind_i)
      lsma_pkg::KIND_ADD: cmd_in.op = lsma_pkg::OP_ADD;
      lsma_pkg::KIND_SUB: cmd_in.op = lsma_pkg::OP_SUB;
      lsma_pkg::KIND_MUL: cmd_in.op = lsma_pkg::OP_MUL;
      lsma_pkg::KIND_AND: cmd_in.op = lsma_pkg::OP_AND;
      lsma_pkg::KIND_CMP: cmd_in.op = lsma_pkg::OP_CMP;
      default:            cmd_in.op = lsma_pkg::OP_NOP;
    endcase
  end

  assign full        = (cnt_q == lsma_pkg::QCntW'(lsma_pkg::QDepth));
  assign cmd_valid_o = (cnt_q != '0);
  assign cmd_o       = cmd_q[rd_ptr_q];
  assign wr_en       = push & ~full;
  assign rd_en       = cmd_take_i & cmd_valid_o;

  always_comb begin
    wr_ptr_d = wr_en ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = rd_en ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q + lsma_pkg::QCntW'(wr_en) - lsma_pkg::QCntW'(rd_en);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      cmd_q[wr_ptr_q] <= cmd_in;
    end
  end

endmodule

/* hdl/lsma_back.sv */
// Back end: limb ALU with running carry and verdict, plus the result queue.
module lsma_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cmd_valid_i,
  input  lsma_pkg::cmd_t       cmd_i,
  output logic                 cmd_take_o,
  output logic                 empty,
  input  logic                 pop,
  output lsma_pkg::res_t       res_o
);

  localparam int unsigned LW = lsma_pkg::LimbW;

  logic [LW-1:0]               carry_q, carry_d;
  logic [1:0]                  verdict_q, verdict_d;
  logic [LW-1:0]               c_in;
  logic [1:0]                  v_in;
  logic [LW+1:0]               sum;
  logic [LW:0]                 subtrahend;
  logic [LW:0]                 diff;
  logic [2*LW-1:0]             prod;
  logic [LW-1:0]               res_limb;
  lsma_pkg::res_t              res_in;
  lsma_pkg::res_t              res_q [lsma_pkg::QDepth];
  logic [lsma_pkg::QPtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [lsma_pkg::QPtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [lsma_pkg::QCntW-1:0]  cnt_q, cnt_d;
  logic                        rd_en;

  assign cmd_take_o = cmd_valid_i & (cnt_q != lsma_pkg::QCntW'(lsma_pkg::QDepth));
  assign rd_en      = pop & ~empty;
  assign empty      = (cnt_q == '0);
  assign res_o      = res_q[rd_ptr_q];

  // A first limb starts from a clear carry and an equal verdict.
  assign c_in = cmd_i.first ? '0 : carry_q;
  assign v_in = cmd_i.first ? lsma_pkg::VERDICT_EQ : verdict_q;

  assign sum        = (LW+2)'(cmd_i.a) + (LW+2)'(cmd_i.b) + (LW+2)'(c_in);
  assign subtrahend = (LW+1)'(cmd_i.b) + (LW+1)'(c_in);
  assign diff       = (LW+1)'(cmd_i.a) - subtrahend;
  assign prod       = (2*LW)'(cmd_i.a) * (2*LW)'(cmd_i.b) + (2*LW)'(c_in);

  always_comb begin
    res_limb  = '0;
    carry_d   = c_in;
    verdict_d = v_in;
    case (cmd_i.op)
      lsma_pkg::OP_ADD: begin
        res_limb = sum[LW-1:0];
        carry_d  = LW'(sum[LW+1:LW]);
      end
      lsma_pkg::OP_SUB: begin
        res_limb = diff[LW-1:0];
        carry_d  = LW'((LW+1)'(cmd_i.a) < subtrahend);
      end
      lsma_pkg::OP_MUL: begin
        res_limb = prod[LW-1:0];
        carry_d  = prod[2*LW-1:LW];
      end
      lsma_pkg::OP_AND: begin
        res_limb = cmd_i.a & cmd_i.b;
        carry_d  = '0;
      end
      lsma_pkg::OP_CMP: begin
        if (cmd_i.a > cmd_i.b) begin
          verdict_d = lsma_pkg::VERDICT_GT;
        end else if (cmd_i.a < cmd_i.b) begin
          verdict_d = lsma_pkg::VERDICT_LT;
        end
      end
      default: begin
        res_limb = '0;
      end
    endcase
  end

  // Report carry and verdict only on the last limb of a run.
  always_comb begin
    res_in.limb    = lsma_pkg::DataW'(res_limb);
    res_in.carry   = '0;
    res_in.verdict = lsma_pkg::VERDICT_EQ;
    res_in.done    = cmd_i.last;
    if (cmd_i.last) begin
      if (cmd_i.op inside {lsma_pkg::OP_ADD, lsma_pkg::OP_SUB, lsma_pkg::OP_MUL}) begin
        res_in.carry = lsma_pkg::DataW'(carry_d);
      end
      if (cmd_i.op == lsma_pkg::OP_CMP) begin
        res_in.verdict = verdict_d;
      end
    end
  end

  always_comb begin
    wr_ptr_d = cmd_take_o ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = rd_en ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q + lsma_pkg::QCntW'(cmd_take_o) - lsma_pkg::QCntW'(rd_en);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      carry_q   <= '0;
      verdict_q <= lsma_pkg::VERDICT_EQ;
      wr_ptr_q  <= '0;
      rd_ptr_q  <= '0;
      cnt_q     <= '0;
    end else begin
      if (cmd_take_o) begin
        carry_q   <= carry_d;
        verdict_q <= verdict_d;
      end
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_take_o) begin
      res_q[wr_ptr_q] <= res_in;
    end
  end

`ifndef SYNTH
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= lsma_pkg::QCntW'(lsma_pkg::QDepth))
    else $error("result queue count overflow");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    verdict_q != 2'b10)
    else $error("verdict register holds an invalid code");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_take_o && cmd_i.op == lsma_pkg::OP_SUB |=> carry_q <= LW'(1))
    else $error("borrow after subtract exceeds one");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_take_o && cmd_i.op == lsma_pkg::OP_AND |=> carry_q == '0)
    else $error("carry not cleared after and");
`endif

endmodule

/* hdl/limb_serial_multiprecision_alu_top.sv */
// Top level of the limb-serial multiprecision ALU: front end, back end and their wiring.
//
// Usage: operands stream in one limb pair per request, least significant limb
// first, with first_i on the lowest limb and last_i on the highest. The input
// side is a queue: a request is taken when push is high and full is low. The
// result side is a queue too: the oldest result sits on the result ports while
// empty is low and leaves when pop is high.
// A taken request is written into the front command queue; the back end computes
// its result from the head of that queue and writes it into the result queue,
// from which it reaches the result ports; a full result queue keeps it waiting.
// Throughput: one limb per cycle while the result queue is not full, set by the
// back-end carry loop through the limb adder and the one limb-by-limb multiplier.
// Reset clears both queues, the running carry and the verdict (equal).
// When the receiver stops popping, the two-entry result queue fills, the back
// end stops taking commands, the two-entry command queue fills and full rises;
// no request or result is dropped.
module limb_serial_multiprecision_alu_top (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push,
  output logic                       full,
  input  logic [lsma_pkg::KindW-1:0] kind_i,
  input  logic [lsma_pkg::DataW-1:0] a_limb_i,
  input  logic [lsma_pkg::DataW-1:0] b_limb_i,
  input  logic                       first_i,
  input  logic                       last_i,
  output logic                       empty,
  input  logic                       pop,
  output logic [lsma_pkg::DataW-1:0] result_limb_o,
  output logic [lsma_pkg::DataW-1:0] carry_out_o,
  output logic signed [1:0]          verdict_o,
  output logic                       done_res_o
);

  logic           cmd_valid;
  logic           cmd_take;
  lsma_pkg::cmd_t cmd;
  lsma_pkg::res_t res;

  lsma_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .kind_i      (kind_i),
    .a_limb_i    (a_limb_i),
    .b_limb_i    (b_limb_i),
    .first_i     (first_i),
    .last_i      (last_i),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_take_i  (cmd_take)
  );

  lsma_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_take_o  (cmd_take),
    .empty       (empty),
    .pop         (pop),
    .res_o       (res)
  );

  assign result_limb_o = res.limb;
  assign carry_out_o   = res.carry;
  assign verdict_o     = res.verdict;
  assign done_res_o    = res.done;

endmodule
